>>> rtl/bba_pkg.sv
// Shared constants for the buddy block allocator: word layouts, defaults, request codes.
// No dependencies.
package bba_pkg;

   localparam int POOL_UNITS_DEF = 1024;
   localparam int MAX_OWNERS_DEF = 256;

   localparam int TREE_AW_DEF  = $clog2(POOL_UNITS_DEF) + 1;
   localparam int MASK_W_DEF   = $clog2(POOL_UNITS_DEF) + 1;
   localparam int OWNER_AW_DEF = $clog2(MAX_OWNERS_DEF);
   localparam int START_W_DEF  = $clog2(POOL_UNITS_DEF);
   localparam int LEVEL_W_DEF  = $clog2(MASK_W_DEF + 1);

   localparam int OWNER_W     = 8;
   localparam int REQ_SIZE_W  = 16;
   localparam int GRANT_W     = 11;
   localparam int BSTART_W    = 10;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

endpackage

>>> rtl/buddy_block_allocator.sv
// Buddy block allocator top level: request sequencer, owner valid bits, result register.
// Depends on bba_pkg, bba_tree_ram and bba_owner_ram.
//
// Usage: one request word in on req_*, one response word out on rsp_* for each.
// A request allocates a power-of-two block for an owner or frees that owner's block.
// After reset the tree store is swept clear, one entry a cycle, with req_tready low;
// then the whole pool is one free block and no owner is valid.
// One request is worked at a time. Each access to the tree store is one step, and
// the steps run one level at a time:
//   allocate: read the root, then per level descended read both children and write
//             both back when a block is split, then per level climbed to the root
//             read the buddy and write the parent, clearing both when buddies merge;
//   free:     read the owner record, mark the block free, then climb likewise.
// A zero or oversize request or an unknown owner fails without a tree access; with no
// fitting block an allocate fails during the descent, or after climbing back.
// The response sits in an output register; a new request is taken as soon as the
// result is loaded there, and a stalled receiver holds the block only when the
// next result is ready to be loaded.
module buddy_block_allocator #(
   parameter int POOL_UNITS = bba_pkg::POOL_UNITS_DEF,
   parameter int MAX_OWNERS = bba_pkg::MAX_OWNERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // owner_id [7:0], req_size [23:8]
   input  logic [bba_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // granted_size [10:0], block_start [20:11]
   output logic [bba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // ok [0]
   output logic                            rsp_tuser
);

   localparam int LOG = $clog2(POOL_UNITS);
   localparam int MW  = LOG + 1;
   localparam int AW  = LOG + 1;
   localparam int LW  = $clog2(MW + 1);
   localparam int SW  = LOG;
   localparam int OW  = $clog2(MAX_OWNERS);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PREP  = 4'd2;
   localparam logic [3:0] S_ROOT  = 4'd3;
   localparam logic [3:0] S_DESC  = 4'd4;
   localparam logic [3:0] S_RDR   = 4'd5;
   localparam logic [3:0] S_EVAL  = 4'd6;
   localparam logic [3:0] S_WL    = 4'd7;
   localparam logic [3:0] S_WR    = 4'd8;
   localparam logic [3:0] S_CLIMB = 4'd9;
   localparam logic [3:0] S_CSIB  = 4'd10;
   localparam logic [3:0] S_CZ1   = 4'd11;
   localparam logic [3:0] S_CZ2   = 4'd12;
   localparam logic [3:0] S_FRD   = 4'd13;
   localparam logic [3:0] S_FMK   = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   function automatic logic [MW-1:0] lvbit(input logic [LW-1:0] l);
      lvbit = MW'(1) << (l - LW'(1));
   endfunction

   // deepest level within lo..hi present in mask, zero if none
   function automatic logic [LW-1:0] best(input logic [MW-1:0] m,
                                          input logic [LW-1:0] lo,
                                          input logic [LW-1:0] hi);
      logic [LW-1:0] b;
      b = '0;
      for (int i = 1; i <= MW; i++) begin
         if (m[i-1] && LW'(i) >= lo && LW'(i) <= hi) begin
            b = LW'(i);
         end
      end
      return b;
   endfunction

   logic [3:0]                     state_ff, state_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic                           func_ff, func_in;
   logic [bba_pkg::OWNER_W-1:0]    id_ff, id_in;
   logic [bba_pkg::REQ_SIZE_W-1:0] req_ff, req_in;
   logic [LW-1:0]                  k_ff, k_in;
   logic [LW-1:0]                  tgt_ff, tgt_in;
   logic [AW-1:0]                  n_ff, n_in;
   logic [LW-1:0]                  lv_ff, lv_in;
   logic [MW-1:0]                  m_ff, m_in;
   logic [MW-1:0]                  lm_ff, lm_in;
   logic [MW-1:0]                  rm_ff, rm_in;
   logic [AW-1:0]                  pair_ff, pair_in;
   logic                           ok_ff, ok_in;
   logic [SW-1:0]                  start_ff, start_in;
   logic [MAX_OWNERS-1:0]          valid_ff, valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_ok_ff, rsp_ok_in;
   logic [bba_pkg::GRANT_W-1:0]    rsp_size_ff, rsp_size_in;
   logic [bba_pkg::BSTART_W-1:0]   rsp_start_ff, rsp_start_in;

   logic          t_we;
   logic [AW-1:0] t_waddr, t_raddr;
   logic [MW-1:0] t_wdata, t_rdata;
   logic          o_we;
   logic [OW-1:0] o_raddr;
   logic [SW-1:0] o_rstart;
   logic [LW-1:0] o_rlevel;
   logic [OW-1:0] idx;

   logic [bba_pkg::REQ_SIZE_W-1:0] rm1;
   logic [LW-1:0]                  kc;
   logic                           split;
   logic [MW-1:0]                  lmx, rmx, lft, rgt, nb;
   logic [LW-1:0]                  bl, br, d, sh;
   logic [AW-1:0]                  nlow;

   bba_tree_ram #(.ADDR_W(AW), .DATA_W(MW)) u_tree (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   bba_owner_ram #(.ADDR_W(OW), .START_W(SW), .LEVEL_W(LW)) u_owner (
      .clock    (clock),
      .wr_en    (o_we),
      .wr_addr  (idx),
      .wr_start (start_in),
      .wr_level (lv_ff),
      .rd_addr  (o_raddr),
      .rd_start (o_rstart),
      .rd_level (o_rlevel)
   );

   assign idx = OW'(id_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      req_in       = req_ff;
      k_in         = k_ff;
      tgt_in       = tgt_ff;
      n_in         = n_ff;
      lv_in        = lv_ff;
      m_in         = m_ff;
      lm_in        = lm_ff;
      rm_in        = rm_ff;
      pair_in      = pair_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_start_in = rsp_start_ff;
      t_we         = 1'b0;
      t_waddr      = n_ff;
      t_wdata      = '0;
      t_raddr      = n_ff;
      o_we         = 1'b0;
      o_raddr      = idx;
      rm1          = req_ff - 16'd1;
      kc           = '0;
      for (int i = 0; i < bba_pkg::REQ_SIZE_W; i++) begin
         if (rm1[i]) begin
            kc = LW'(i + 1);
         end
      end
      split = |(m_ff & lvbit(lv_ff));
      nb    = split ? lvbit(lv_ff + LW'(1)) : '0;
      lmx   = lm_ff | nb;
      rmx   = t_rdata | nb;
      bl    = best(lmx, lv_ff + LW'(1), tgt_ff);
      br    = best(rmx, lv_ff + LW'(1), tgt_ff);
      lft   = n_ff[0] ? t_rdata : m_ff;
      rgt   = n_ff[0] ? m_ff : t_rdata;
      d     = o_rlevel - LW'(1);
      sh    = LW'(LOG) - (lv_ff - LW'(1));
      nlow  = n_ff & ~(AW'(1) << (lv_ff - LW'(1)));

      case (state_ff)
         S_CLR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
            t_wdata = (clr_ff == AW'(1)) ? MW'(1) : '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               id_in    = req_tdata[7:0];
               req_in   = req_tdata[23:8];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            ok_in    = 1'b0;
            start_in = '0;
            if (32'(id_ff) >= 32'(MAX_OWNERS)) begin
               state_in = S_OUT;
            end else if (func_ff == bba_pkg::FUNC_FREE) begin
               state_in = valid_ff[idx] ? S_FRD : S_OUT;
            end else if (req_ff == '0 || 32'(req_ff) > 32'(POOL_UNITS)) begin
               state_in = S_OUT;
            end else begin
               k_in     = kc;
               tgt_in   = LW'(MW) - kc;
               t_raddr  = AW'(1);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            m_in     = t_rdata;
            n_in     = AW'(1);
            lv_in    = LW'(1);
            state_in = S_DESC;
         end
         S_DESC: begin
            if (lv_ff < tgt_ff) begin
               t_raddr  = {n_ff[AW-2:0], 1'b0};
               state_in = S_RDR;
            end else if (split) begin
               t_we     = 1'b1;
               t_wdata  = m_ff & ~lvbit(lv_ff);
               m_in     = m_ff & ~lvbit(lv_ff);
               ok_in    = 1'b1;
               start_in = SW'(AW'(nlow << sh));
               o_we     = 1'b1;
               valid_in[idx] = 1'b1;
               state_in = S_CLIMB;
            end else begin
               state_in = S_CLIMB;
            end
         end
         S_RDR: begin
            lm_in    = t_rdata;
            t_raddr  = {n_ff[AW-2:0], 1'b1};
            state_in = S_EVAL;
         end
         S_EVAL: begin
            t_we    = split;
            t_wdata = m_ff & ~lvbit(lv_ff);
            if (bl == '0 && br == '0) begin
               state_in = S_OUT;
            end else begin
               lm_in    = lmx;
               rm_in    = rmx;
               pair_in  = {n_ff[AW-2:0], 1'b0};
               n_in     = {n_ff[AW-2:0], ~(bl >= br)};
               m_in     = (bl >= br) ? lmx : rmx;
               lv_in    = lv_ff + LW'(1);
               state_in = split ? S_WL : S_DESC;
            end
         end
         S_WL: begin
            t_we     = 1'b1;
            t_waddr  = pair_ff;
            t_wdata  = lm_ff;
            state_in = S_WR;
         end
         S_WR: begin
            t_we     = 1'b1;
            t_waddr  = pair_ff | AW'(1);
            t_wdata  = rm_ff;
            state_in = S_DESC;
         end
         S_CLIMB: begin
            if (n_ff == AW'(1)) begin
               state_in = S_OUT;
            end else begin
               t_raddr  = n_ff ^ AW'(1);
               state_in = S_CSIB;
            end
         end
         S_CSIB: begin
            t_we    = 1'b1;
            t_waddr = n_ff >> 1;
            pair_in = n_ff & ~AW'(1);
            n_in    = n_ff >> 1;
            lv_in   = lv_ff - LW'(1);
            if ((|(lft & lvbit(lv_ff))) && (|(rgt & lvbit(lv_ff)))) begin
               t_wdata  = lvbit(lv_ff - LW'(1));
               m_in     = lvbit(lv_ff - LW'(1));
               state_in = S_CZ1;
            end else begin
               t_wdata  = lft | rgt;
               m_in     = lft | rgt;
               state_in = S_CLIMB;
            end
         end
         S_CZ1: begin
            t_we     = 1'b1;
            t_waddr  = pair_ff;
            state_in = S_CZ2;
         end
         S_CZ2: begin
            t_we     = 1'b1;
            t_waddr  = pair_ff | AW'(1);
            state_in = S_CLIMB;
         end
         S_FRD: begin
            start_in = o_rstart;
            lv_in    = o_rlevel;
            n_in     = (AW'(1) << d) | AW'(o_rstart >> (LW'(LOG) - d));
            t_raddr  = (AW'(1) << d) | AW'(o_rstart >> (LW'(LOG) - d));
            state_in = S_FMK;
         end
         S_FMK: begin
            t_we     = 1'b1;
            t_wdata  = t_rdata | lvbit(lv_ff);
            m_in     = t_rdata | lvbit(lv_ff);
            ok_in    = 1'b1;
            valid_in[idx] = 1'b0;
            state_in = S_CLIMB;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_size_in  = (ok_ff && func_ff == bba_pkg::FUNC_ALLOC) ?
                              bba_pkg::GRANT_W'(32'(1) << k_ff) : '0;
               rsp_start_in = bba_pkg::BSTART_W'(start_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      id_ff        <= id_in;
      req_ff       <= req_in;
      k_ff         <= k_in;
      tgt_ff       <= tgt_in;
      n_ff         <= n_in;
      lv_ff        <= lv_in;
      m_ff         <= m_in;
      lm_ff        <= lm_in;
      rm_ff        <= rm_in;
      pair_ff      <= pair_in;
      ok_ff        <= ok_in;
      start_ff     <= start_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_start_ff, rsp_size_ff};
   assign rsp_tuser  = rsp_ok_ff;

`ifndef SYNTHESIS
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_PREP)
      else $error("accepted word did not start a request");

   a_desc_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DESC |-> lv_ff >= LW'(1) && lv_ff <= tgt_ff)
      else $error("descent level out of range");

   a_grant_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_size_ff != '0 |-> $onehot(rsp_size_ff) && rsp_ok_ff)
      else $error("granted size not a power of two");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_size_ff == '0 && rsp_start_ff == '0)
      else $error("failed response carries a block");
`endif

endmodule

>>> rtl/bba_tree_ram.sv
// Node free-mask store of the buddy tree: one write port, one registered read port.
// Depends on bba_pkg for default widths.
module bba_tree_ram #(
   parameter int ADDR_W = bba_pkg::TREE_AW_DEF,
   parameter int DATA_W = bba_pkg::MASK_W_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bba_owner_ram.sv
// Owner record store: start unit and tree level of each owner's block.
// Depends on bba_pkg for default widths.
module bba_owner_ram #(
   parameter int ADDR_W  = bba_pkg::OWNER_AW_DEF,
   parameter int START_W = bba_pkg::START_W_DEF,
   parameter int LEVEL_W = bba_pkg::LEVEL_W_DEF
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [START_W-1:0] wr_start,
   input  logic [LEVEL_W-1:0] wr_level,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [START_W-1:0] rd_start,
   output logic [LEVEL_W-1:0] rd_level
);

   logic [START_W+LEVEL_W-1:0] mem [2**ADDR_W];
   logic [START_W+LEVEL_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_level, wr_start};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_start = rd_ff[START_W-1:0];
   assign rd_level = rd_ff[START_W+LEVEL_W-1:START_W];

endmodule
